FILE: rtl/core/dial_angle_from_saturation_mask_defines.svh
// Assertion macros for the dial angle block.
`ifndef DIAL_ANGLE_FROM_SATURATION_MASK_DEFINES_SVH
`define DIAL_ANGLE_FROM_SATURATION_MASK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/das_pkg.sv
// Shared types, constants and the circle table of the dial angle block.
`timescale 1ns / 1ps
package das_pkg;
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int MASK_SIZE    = 150;
    localparam int ANGLE_STEPS  = 360;
    localparam int RING_CX      = 75;
    localparam int RING_CY      = 80;
    localparam int MASK_DEPTH   = MASK_SIZE * MASK_SIZE;
    localparam int ADDR_W       = $clog2(MASK_DEPTH);
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);
    localparam int MPOS_W       = $clog2(MASK_SIZE);
    localparam int DEG_W        = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic REG_CROP_LEFT = 1'b0;
    localparam logic REG_CROP_TOP  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [8:0] angle;
        logic [8:0] forward_angle;
        logic [8:0] backward_angle;
        logic [2:0] peak_sum;
    } t_result;

    // Entry passed from the classifier to the scanner.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic              bit_val;
        logic              last;
    } t_mask_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DONE,
        ST_OUT
    } t_scan_state;

    // floor(60 sin(a)) for a = 0..90.
    localparam logic [5:0] QUARTER_SINE [0:90] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd36, 6'd37,
        6'd38, 6'd39, 6'd40, 6'd40, 6'd41, 6'd42, 6'd43, 6'd43, 6'd44, 6'd45,
        6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49, 6'd49, 6'd50, 6'd50, 6'd51,
        6'd51, 6'd52, 6'd52, 6'd53, 6'd53, 6'd54, 6'd54, 6'd55, 6'd55, 6'd56,
        6'd56, 6'd56, 6'd57, 6'd57, 6'd57, 6'd57, 6'd58, 6'd58, 6'd58, 6'd58,
        6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59,
        6'd60
    };

    function automatic int ring_floor(int mid, int a, bit negative);
        int  t;
        bit  exact;
        t = int'(QUARTER_SINE[a]);
        exact = (a == 0) || (a == 30) || (a == 90);
        if (!negative) return mid + t;
        return mid - t - (exact ? 0 : 1);
    endfunction

    // Circle point x (column) for a degree 0..360.
    function automatic logic [7:0] ring_x(logic [DEG_W-1:0] deg);
        int d;
        int x;
        d = int'(deg);
        if (d <= 90) x = ring_floor(RING_CX, 90 - d, 1'b0);
        else if (d <= 180) x = ring_floor(RING_CX, d - 90, 1'b1);
        else if (d <= 270) x = ring_floor(RING_CX, 270 - d, 1'b1);
        else x = ring_floor(RING_CX, d - 270, 1'b0);
        if (d == 240) x = 44;
        if (d == 270) x = 74;
        return x[7:0];
    endfunction

    // Circle point y (row) for a degree 0..360.
    function automatic logic [7:0] ring_y(logic [DEG_W-1:0] deg);
        int d;
        int y;
        d = int'(deg);
        if (d <= 90) y = ring_floor(RING_CY, d, 1'b0);
        else if (d <= 180) y = ring_floor(RING_CY, 180 - d, 1'b0);
        else if (d <= 270) y = ring_floor(RING_CY, d - 180, 1'b1);
        else y = ring_floor(RING_CY, 360 - d, 1'b1);
        if (d == 210 || d == 330) y = 49;
        if (d == 360) y = 79;
        return y[7:0];
    endfunction
endpackage

FILE: rtl/core/dial_angle_from_saturation_mask.sv
// Top level of the dial angle block.
// Use: pixels of a frame enter in raster order on i_pix_valid / o_pix_stall,
// FRAME_WIDTH per row; the one with last_pixel set closes the frame.
// One pixel is taken per cycle while the mask is filled; a four-entry queue
// parts the classifier from the mask writer and scanner.
// After the last pixel the scanner walks 360 degrees forward and back,
// making five mask reads through one registered port and one compare
// per degree; the walk starts once the pixels still waiting in the queue
// ahead of the last one are written, and the result follows the walk.
// Pixels that follow are held in the queue and then stalled until the
// result has been taken.
// The result sits on o_res_valid / i_res_stall and holds while stalled.
// Configuration: write crop_left (index 0) or crop_top (index 1) on
// i_cfg_valid / o_cfg_ready while the block is idle.
// Reset clears counters and control, restores the crop registers; the mask
// holds no defined data until written and needs no clearing pass.
`timescale 1ns / 1ps
module dial_angle_from_saturation_mask (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pix_valid,
    input  das_pkg::t_pixel  i_pix,
    output logic             o_pix_stall,
    output logic             o_res_valid,
    output das_pkg::t_result o_res,
    input  logic             i_res_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    logic [7:0] r_crop_left;
    logic [6:0] r_crop_top;
    logic accept, q_full, q_empty, q_pop;
    das_pkg::t_mask_op op_in, op_out;

    assign o_pix_stall = q_full;
    assign accept = i_pix_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    // Hold the crop registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_left <= 8'd100;
            r_crop_top  <= 7'd45;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                das_pkg::REG_CROP_LEFT: r_crop_left <= i_cfg_data;
                das_pkg::REG_CROP_TOP:  r_crop_top  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    das_classify u_classify (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_pix_valid), .i_pixel(i_pix),
        .i_accept(accept), .i_crop_left(r_crop_left), .i_crop_top(r_crop_top),
        .o_op(op_in)
    );

    das_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(accept), .i_data(op_in),
        .i_pop(q_pop), .o_full(q_full), .o_empty(q_empty), .o_data(op_out)
    );

    das_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op_valid(!q_empty), .i_op(op_out),
        .o_op_pop(q_pop), .o_res_valid(o_res_valid), .o_res(o_res),
        .i_res_stall(i_res_stall)
    );
endmodule

FILE: rtl/core/das_classify.sv
// Front end: pixel position tracking, crop window and saturation test.
`timescale 1ns / 1ps
`include "dial_angle_from_saturation_mask_defines.svh"
module das_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  das_pkg::t_pixel   i_pixel,
    input  logic              i_accept,
    input  logic [7:0]        i_crop_left,
    input  logic [6:0]        i_crop_top,
    output das_pkg::t_mask_op o_op
);
    logic [das_pkg::COL_W-1:0] r_col, n_col;
    logic [das_pkg::ROW_W-1:0] r_row, n_row;
    logic [7:0] hi, lo;
    logic [8:0] sum;
    logic [10:0] diff5;
    logic       sat;
    logic [das_pkg::COL_W:0] mx;
    logic [das_pkg::ROW_W:0] my;
    logic in_win;
    logic [das_pkg::ADDR_W-1:0] addr;

    // Find channel extremes and run the exact saturation test.
    always_comb begin
        hi = i_pixel.red;
        lo = i_pixel.red;
        if (i_pixel.green > hi) hi = i_pixel.green;
        if (i_pixel.green < lo) lo = i_pixel.green;
        if (i_pixel.blue > hi) hi = i_pixel.blue;
        if (i_pixel.blue < lo) lo = i_pixel.blue;
        sum = {1'b0, hi} + {1'b0, lo};
        diff5 = 11'(hi - lo) * 11'd5;
        if (hi == lo) sat = 1'b0;
        else if (sum < 9'd255) sat = diff5 > 11'(sum);
        else sat = diff5 > (11'd510 - 11'(sum));
    end

    // Map the frame position into the crop window.
    always_comb begin
        mx = {1'b0, r_col} - (das_pkg::COL_W + 1)'(i_crop_left);
        my = {1'b0, r_row} - (das_pkg::ROW_W + 1)'(i_crop_top);
        in_win = (r_col >= das_pkg::COL_W'(i_crop_left))
              && (r_row >= das_pkg::ROW_W'(i_crop_top))
              && (mx < (das_pkg::COL_W + 1)'(das_pkg::MASK_SIZE))
              && (my < (das_pkg::ROW_W + 1)'(das_pkg::MASK_SIZE));
        addr = das_pkg::ADDR_W'(my[das_pkg::MPOS_W-1:0] * das_pkg::MASK_SIZE)
             + das_pkg::ADDR_W'(mx[das_pkg::MPOS_W-1:0]);
        o_op.wr_en   = in_win;
        o_op.addr    = addr;
        o_op.bit_val = sat;
        o_op.last    = i_pixel.last_pixel;
    end

    // Advance raster counters on each accepted transaction.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (i_pixel.last_pixel) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == das_pkg::COL_W'(das_pkg::FRAME_WIDTH - 1)) begin
                n_col = '0;
                n_row = (r_row == das_pkg::ROW_W'(das_pkg::FRAME_HEIGHT - 1)) ?
                        '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `DAS_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, 1'b1,
        r_col < das_pkg::COL_W'(das_pkg::FRAME_WIDTH), "column out of range")
    `DAS_ASSERT_IMPL(a_row_range, i_clk, i_rst_n, 1'b1,
        r_row < das_pkg::ROW_W'(das_pkg::FRAME_HEIGHT), "row out of range")
    `DAS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_pixel.last_pixel,
        r_col == '0 && r_row == '0, "counters not cleared after last pixel")
    `DAS_ASSERT_IMPL(a_valid_accept, i_clk, i_rst_n, i_accept, i_valid,
        "accept without valid")
endmodule

FILE: rtl/core/das_queue.sv
// Short queue between classifier and scanner.
`timescale 1ns / 1ps
module das_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  das_pkg::t_mask_op i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output das_pkg::t_mask_op o_data
);
    das_pkg::t_mask_op r_mem [das_pkg::QUEUE_DEPTH];
    logic [das_pkg::QPTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [das_pkg::QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (das_pkg::QPTR_W + 1)'(das_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers on push and pop.
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (das_pkg::QPTR_W + 1)'(i_push) - (das_pkg::QPTR_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: rtl/core/das_scan.sv
// Back end: mask memory, circle walk and peak search.
`timescale 1ns / 1ps
`include "dial_angle_from_saturation_mask_defines.svh"
module das_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  das_pkg::t_mask_op i_op,
    output logic              o_op_pop,
    output logic              o_res_valid,
    output das_pkg::t_result  o_res,
    input  logic              i_res_stall
);
    das_pkg::t_scan_state r_state, n_state;
    logic r_mem [das_pkg::MASK_DEPTH];
    // Scan control: degree, tap (0..5, 5 = accumulate last read), sums.
    logic [das_pkg::DEG_W-1:0] r_deg, n_deg;
    logic [2:0] r_tap, n_tap;
    logic [2:0] r_acc, n_acc;
    logic       r_rvalid;
    logic       r_rbit;
    logic       r_tap_ok, n_tap_ok;
    logic [2:0] r_best_f, n_best_f, r_best_b, n_best_b;
    logic [das_pkg::DEG_W-1:0] r_fwd, n_fwd, r_bwd, n_bwd;
    das_pkg::t_result r_res, n_res;
    logic [7:0] cx, cy;
    logic signed [9:0] px, py;
    logic tap_in;
    logic rd_en;
    logic [das_pkg::ADDR_W-1:0] rd_addr;
    logic [2:0] sum_now;
    logic [das_pkg::DEG_W:0] mean;

    // Pick the tap point of the cross.
    always_comb begin
        cx = das_pkg::ring_x(r_deg);
        cy = das_pkg::ring_y(r_deg);
        px = 10'(cx);
        py = 10'(cy);
        unique case (r_tap)
            3'd1: px = 10'(cx) - 10'sd1;
            3'd2: px = 10'(cx) + 10'sd1;
            3'd3: py = 10'(cy) - 10'sd1;
            3'd4: py = 10'(cy) + 10'sd1;
            default: ;
        endcase
        tap_in = (px >= 0) && (py >= 0) && (px < 10'(das_pkg::MASK_SIZE))
              && (py < 10'(das_pkg::MASK_SIZE));
        rd_addr = das_pkg::ADDR_W'(py[7:0] * das_pkg::MASK_SIZE) + das_pkg::ADDR_W'(px[7:0]);
    end

    assign rd_en = (r_state == das_pkg::ST_FWD || r_state == das_pkg::ST_BWD)
                && (r_tap < 3'd5);
    assign sum_now = r_acc + ((r_rvalid && r_tap_ok) ? {2'b0, r_rbit} : 3'd0);
    assign mean = ({1'b0, r_fwd} + {1'b0, r_bwd}) >> 1;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            das_pkg::ST_IDLE:
                if (i_op_valid && i_op.last) n_state = das_pkg::ST_FWD;
            das_pkg::ST_FWD:
                if (r_tap == 3'd5 && r_deg == das_pkg::DEG_W'(das_pkg::ANGLE_STEPS - 1))
                    n_state = das_pkg::ST_BWD;
            das_pkg::ST_BWD:
                if (r_tap == 3'd5 && r_deg == das_pkg::DEG_W'(1)) n_state = das_pkg::ST_DONE;
            das_pkg::ST_DONE: n_state = das_pkg::ST_OUT;
            das_pkg::ST_OUT: if (!i_res_stall) n_state = das_pkg::ST_IDLE;
            default: n_state = das_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_deg = r_deg;
        n_tap = r_tap;
        n_acc = r_acc;
        n_tap_ok = tap_in;
        n_best_f = r_best_f;
        n_best_b = r_best_b;
        n_fwd = r_fwd;
        n_bwd = r_bwd;
        n_res = r_res;
        o_op_pop = 1'b0;
        unique case (r_state)
            das_pkg::ST_IDLE: begin
                o_op_pop = i_op_valid;
                n_deg = '0;
                n_tap = '0;
                n_acc = '0;
                n_best_f = '0;
                n_best_b = '0;
                n_fwd = '0;
                n_bwd = '0;
            end
            das_pkg::ST_FWD, das_pkg::ST_BWD: begin
                if (r_tap == 3'd5) begin
                    n_tap = '0;
                    n_acc = '0;
                    if (r_state == das_pkg::ST_FWD) begin
                        if (sum_now > r_best_f) begin
                            n_best_f = sum_now;
                            n_fwd = r_deg;
                        end
                        n_deg = (r_deg == das_pkg::DEG_W'(das_pkg::ANGLE_STEPS - 1)) ?
                                das_pkg::DEG_W'(das_pkg::ANGLE_STEPS) : r_deg + 1'b1;
                    end else begin
                        if (sum_now > r_best_b) begin
                            n_best_b = sum_now;
                            n_bwd = r_deg;
                        end
                        n_deg = r_deg - 1'b1;
                    end
                end else begin
                    n_tap = r_tap + 1'b1;
                    n_acc = sum_now;
                end
            end
            das_pkg::ST_DONE: begin
                n_res.angle = mean[das_pkg::DEG_W-1:0];
                n_res.forward_angle = r_fwd;
                n_res.backward_angle = r_bwd;
                n_res.peak_sum = (r_best_f > r_best_b) ? r_best_f : r_best_b;
            end
            das_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    assign o_res_valid = (r_state == das_pkg::ST_OUT);
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= das_pkg::ST_IDLE;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg <= n_deg;
        r_tap <= n_tap;
        r_acc <= n_acc;
        r_tap_ok <= n_tap_ok;
        r_best_f <= n_best_f;
        r_best_b <= n_best_b;
        r_fwd <= n_fwd;
        r_bwd <= n_bwd;
        r_res <= n_res;
    end

    // Mask memory: write from queue, registered read during the walk.
    always_ff @(posedge i_clk) begin
        if (o_op_pop && i_op.wr_en) r_mem[i_op.addr] <= i_op.bit_val;
        if (rd_en) r_rbit <= r_mem[rd_addr];
    end

    `DAS_ASSERT_IMPL(a_tap_range, i_clk, i_rst_n, rd_en, r_tap < 3'd5, "bad tap")
    `DAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res_valid && i_res_stall,
        o_res_valid, "result dropped under stall")
    `DAS_ASSERT_IMPL(a_no_pop_busy, i_clk, i_rst_n, o_op_pop,
        r_state == das_pkg::ST_IDLE, "pop while scanning")
endmodule

FILE: tb/dial_angle_from_saturation_mask_test.sv
// Self-checking testbench of the dial angle block: streamed frames, crop settings, result checks.
`timescale 1ns / 1ps
module dial_angle_from_saturation_mask_test;

    typedef enum int {
        EV_PIXEL,
        EV_CFG,
        EV_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind      kind;
        das_pkg::t_pixel pix;
        logic            idx;
        logic [7:0]      data;
    } t_stim;

    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 5000;
    localparam int HOLD_CYCLES   = 6000;
    localparam int IDLE_PCT      = 32;
    localparam int QUIET_FROM    = 20000;
    localparam int QUIET_TO      = 45000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             pix_valid = 1'b0;
    das_pkg::t_pixel  pix_data = '0;
    logic             o_pix_stall;
    logic             o_res_valid;
    das_pkg::t_result o_res;
    logic             res_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             cfg_idx = das_pkg::REG_CROP_LEFT;
    logic [7:0]       cfg_data = '0;

    dial_angle_from_saturation_mask DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_valid),
        .i_pix       (pix_data),
        .o_pix_stall (o_pix_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (res_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus queue and checker state
    t_stim            pending[$];
    das_pkg::t_result dial_expect[$];
    int      errors = 0;
    int      results_seen = 0;
    int      pixels_taken = 0;
    int      cfg_writes = 0;
    int      cycle_count = 0;

    // Predictor state
    bit      mask_bits [das_pkg::MASK_DEPTH];
    int      col_pos = 0;
    int      row_pos = 0;
    int      left_reg = 100;
    int      top_reg = 45;

    // floor(60 sin(a)) for a = 0..90
    const int sine60 [0:90] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
        20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 30, 31, 32, 33, 34, 35, 36, 36, 37,
        38, 39, 40, 40, 41, 42, 43, 43, 44, 45, 45, 46, 47, 47, 48, 49, 49, 50, 50, 51,
        51, 52, 52, 53, 53, 54, 54, 55, 55, 56, 56, 56, 57, 57, 57, 57, 58, 58, 58, 58,
        59, 59, 59, 59, 59, 59, 59, 59, 59, 59, 60
    };

    // floor(60 sin(a)) for any whole degree a >= 0
    function automatic int floor_sine60(int a);
        int r;
        int q;
        r = a % 360;
        if (r <= 90) return sine60[r];
        if (r <= 180) return sine60[180 - r];
        q = (r <= 270) ? r - 180 : 360 - r;
        return -sine60[q] - ((q == 0 || q == 30 || q == 90) ? 0 : 1);
    endfunction

    function automatic int mask_bit(int x, int y);
        if (x < 0 || y < 0 || x >= das_pkg::MASK_SIZE || y >= das_pkg::MASK_SIZE) return 0;
        return int'(mask_bits[y * das_pkg::MASK_SIZE + x]);
    endfunction

    function automatic int cross_count(int deg);
        int x;
        int y;
        x = das_pkg::RING_CX + floor_sine60(deg + 90);
        y = das_pkg::RING_CY + floor_sine60(deg);
        // the double-precision table lands one below at these degrees
        if (deg == 240) x = 44;
        if (deg == 270) x = 74;
        if (deg == 210 || deg == 330) y = 49;
        if (deg == 360) y = 79;
        return mask_bit(x, y) + mask_bit(x - 1, y) + mask_bit(x + 1, y) +
               mask_bit(x, y - 1) + mask_bit(x, y + 1);
    endfunction

    function automatic das_pkg::t_result dial_scan();
        das_pkg::t_result res;
        int fwd;
        int bwd;
        int best_f;
        int best_b;
        int s;
        fwd = 0; bwd = 0; best_f = 0; best_b = 0;
        for (int d = 0; d < das_pkg::ANGLE_STEPS; d++) begin
            s = cross_count(d);
            if (s > best_f) begin
                best_f = s;
                fwd = d;
            end
        end
        for (int d = das_pkg::ANGLE_STEPS; d > 0; d--) begin
            s = cross_count(d);
            if (s > best_b) begin
                best_b = s;
                bwd = d;
            end
        end
        res.angle          = 9'((fwd + bwd) / 2);
        res.forward_angle  = 9'(fwd);
        res.backward_angle = 9'(bwd);
        res.peak_sum       = 3'((best_f > best_b) ? best_f : best_b);
        return res;
    endfunction

    function automatic bit is_saturated(das_pkg::t_pixel p);
        int hi;
        int lo;
        hi = p.red; lo = p.red;
        if (p.green > hi) hi = p.green;
        if (p.green < lo) lo = p.green;
        if (p.blue > hi) hi = p.blue;
        if (p.blue < lo) lo = p.blue;
        if (hi == lo) return 1'b0;
        if (hi + lo < 255) return 5 * (hi - lo) > hi + lo;
        return 5 * (hi - lo) > 510 - hi - lo;
    endfunction

    // Update the mask and counters for one accepted pixel; predict the result at the last pixel
    task automatic take_pixel(das_pkg::t_pixel p);
        int mx;
        int my;
        pixels_taken++;
        if (col_pos >= left_reg && row_pos >= top_reg) begin
            mx = col_pos - left_reg;
            my = row_pos - top_reg;
            if (mx < das_pkg::MASK_SIZE && my < das_pkg::MASK_SIZE)
                mask_bits[my * das_pkg::MASK_SIZE + mx] = is_saturated(p);
        end
        if (!p.last_pixel) begin
            col_pos++;
            if (col_pos >= das_pkg::FRAME_WIDTH) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= das_pkg::FRAME_HEIGHT) row_pos = 0;
            end
        end else begin
            col_pos = 0;
            row_pos = 0;
            dial_expect.push_back(dial_scan());
        end
    endtask

    // Directed colors: extremes, primaries and the edges of the threshold
    function automatic das_pkg::t_pixel directed_pixel(int k);
        das_pkg::t_pixel p;
        p.last_pixel = 1'b0;
        case (k)
            0:  {p.red, p.green, p.blue} = {8'd0, 8'd0, 8'd0};
            1:  {p.red, p.green, p.blue} = {8'd255, 8'd255, 8'd255};
            2:  {p.red, p.green, p.blue} = {8'd255, 8'd0, 8'd0};
            3:  {p.red, p.green, p.blue} = {8'd0, 8'd255, 8'd0};
            4:  {p.red, p.green, p.blue} = {8'd0, 8'd0, 8'd255};
            5:  {p.red, p.green, p.blue} = {8'd60, 8'd40, 8'd50};
            6:  {p.red, p.green, p.blue} = {8'd40, 8'd61, 8'd45};
            7:  {p.red, p.green, p.blue} = {8'd215, 8'd200, 8'd195};
            8:  {p.red, p.green, p.blue} = {8'd195, 8'd205, 8'd216};
            9:  {p.red, p.green, p.blue} = {8'd128, 8'd127, 8'd127};
            10: {p.red, p.green, p.blue} = {8'd200, 8'd54, 8'd54};
            11: {p.red, p.green, p.blue} = {8'd170, 8'd85, 8'd255};
            default: {p.red, p.green, p.blue} = {8'd1, 8'd0, 8'd1};
        endcase
        return p;
    endfunction

    // Random color: gray, fully random, or near the threshold
    function automatic das_pkg::t_pixel random_pixel(bit gray_only);
        das_pkg::t_pixel p;
        int base;
        int spread;
        p.last_pixel = 1'b0;
        base = $urandom_range(0, 255);
        if (gray_only || $urandom_range(0, 2) == 0) begin
            {p.red, p.green, p.blue} = {8'(base), 8'(base), 8'(base)};
        end else if ($urandom_range(0, 1) == 0) begin
            p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
        end else begin
            spread = $urandom_range(0, 40);
            p.red   = 8'((base + $urandom_range(0, spread) > 255) ? 255 : base + $urandom_range(0, spread));
            p.green = 8'((base > spread) ? base - $urandom_range(0, spread) : base);
            p.blue  = 8'(base);
        end
        return p;
    endfunction

    task automatic add_frame(int npix, bit gray_only, int dir_at);
        t_stim s;
        s.kind = EV_PIXEL;
        s.idx  = das_pkg::REG_CROP_LEFT;
        s.data = '0;
        for (int k = 0; k < npix; k++) begin
            if (dir_at >= 0 && k >= dir_at && k < dir_at + 13) s.pix = directed_pixel(k - dir_at);
            else s.pix = random_pixel(gray_only);
            s.pix.last_pixel = (k == npix - 1);
            pending.push_back(s);
        end
    endtask

    task automatic add_drain();
        t_stim s;
        s.kind = EV_DRAIN;
        s.pix  = '0;
        s.idx  = das_pkg::REG_CROP_LEFT;
        s.data = '0;
        pending.push_back(s);
    endtask

    // Wait for the block to go idle, then write both crop registers
    task automatic add_crop(int left, int top);
        t_stim s;
        add_drain();
        s.kind = EV_CFG;
        s.pix  = '0;
        s.idx  = das_pkg::REG_CROP_LEFT;
        s.data = 8'(left);
        pending.push_back(s);
        s.idx  = das_pkg::REG_CROP_TOP;
        s.data = 8'(top);
        pending.push_back(s);
    endtask

    // Driver: present pixels and register writes, predict on each transaction
    bit draining = 1'b0;
    int settle = 0;
    always @(posedge i_clk) begin
        bit pix_taken;
        bit cfg_taken;
        bit nv_pix;
        bit nv_cfg;
        bit quiet;
        t_stim s;
        cycle_count++;
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            pix_taken = pix_valid && !o_pix_stall;
            cfg_taken = cfg_valid && o_cfg_ready;
            if (pix_taken) take_pixel(pix_data);
            if (cfg_taken) begin
                cfg_writes++;
                if (cfg_idx == das_pkg::REG_CROP_LEFT) left_reg = int'(cfg_data);
                else top_reg = int'(cfg_data & 8'h7F);
            end
            // hold the transaction until it is taken
            if (!((pix_valid && !pix_taken) || (cfg_valid && !cfg_taken))) begin
                nv_pix = 1'b0;
                nv_cfg = 1'b0;
                quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
                if (draining) begin
                    if (dial_expect.size() == 0) settle++;
                    if (settle >= SETTLE_CYCLES) draining = 1'b0;
                end else if (pending.size() > 0) begin
                    s = pending[0];
                    case (s.kind)
                        EV_DRAIN: begin
                            void'(pending.pop_front());
                            draining = 1'b1;
                            settle = 0;
                        end
                        EV_CFG: begin
                            void'(pending.pop_front());
                            nv_cfg = 1'b1;
                            cfg_idx <= s.idx;
                            cfg_data <= s.data;
                        end
                        default: begin
                            if (quiet || $urandom_range(0, 99) >= IDLE_PCT) begin
                                void'(pending.pop_front());
                                nv_pix = 1'b1;
                                pix_data <= s.pix;
                            end
                        end
                    endcase
                end
                pix_valid <= nv_pix;
                cfg_valid <= nv_cfg;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    int  hold_left = 0;
    bit  hold_armed = 1'b0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        bit nv;
        bit quiet;
        das_pkg::t_result e;
        if (!i_rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (o_res_valid && !res_stall) begin
                if (dial_expect.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, actual %p", $time, o_res);
                end else begin
                    e = dial_expect.pop_front();
                    if (o_res.angle !== e.angle)
                        $display("%0t: angle expected %0d actual %0d", $time, e.angle, o_res.angle);
                    if (o_res.forward_angle !== e.forward_angle)
                        $display("%0t: forward_angle expected %0d actual %0d", $time,
                                 e.forward_angle, o_res.forward_angle);
                    if (o_res.backward_angle !== e.backward_angle)
                        $display("%0t: backward_angle expected %0d actual %0d", $time,
                                 e.backward_angle, o_res.backward_angle);
                    if (o_res.peak_sum !== e.peak_sum)
                        $display("%0t: peak_sum expected %0d actual %0d", $time,
                                 e.peak_sum, o_res.peak_sum);
                    if (o_res !== e) errors++;
                end
                results_seen++;
            end
            // after the first result, stall until the next shows, then hold it off longer
            quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
            if (!hold_done && results_seen == 1 && !hold_armed) hold_armed = 1'b1;
            if (hold_armed && !hold_done && o_res_valid && res_stall && results_seen == 1) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_armed && !hold_done) begin
                nv = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                nv = 1'b1;
            end else begin
                nv = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            end
            res_stall <= nv;
        end
    end

    // Build the stimulus, run reset, wait for the end
    initial begin
        int rows;
        int top;
        // whole frame of gray pixels past the last row: defines every mask bit, all sums zero
        add_frame((das_pkg::FRAME_HEIGHT + 1) * das_pkg::FRAME_WIDTH + 7, 1'b1, -1);
        // random frame with directed colors on the circle row, then a short one behind it
        add_frame(200 * das_pkg::FRAME_WIDTH, 1'b0,
                  (45 + 80) * das_pkg::FRAME_WIDTH + 100 + 130);
        add_frame(8, 1'b0, -1);
        add_crop(0, 0);
        add_frame(30 * das_pkg::FRAME_WIDTH + 11, 1'b0, -1);
        add_frame(1, 1'b0, -1);
        add_crop(170, 90);
        add_frame(5, 1'b0, 0);
        add_crop(100, 45);
        add_frame(3, 1'b0, -1);
        for (int f = 0; f < 30; f++) begin
            if ($urandom_range(0, 2) == 0) begin
                top = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 20);
                add_crop($urandom_range(0, 170), top);
            end
            if ($urandom_range(0, 9) < 4) begin
                add_frame($urandom_range(1, 64), 1'b0, -1);
            end else begin
                rows = $urandom_range(20, 45);
                add_frame(rows * das_pkg::FRAME_WIDTH
                          + $urandom_range(0, das_pkg::FRAME_WIDTH - 1), 1'b0, -1);
            end
        end
        add_drain();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending.size() > 0 || pix_valid || cfg_valid || draining || dial_expect.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (dial_expect.size() > 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, dial_expect.size());
        end
        $display("Streamed %0d pixels over %0d register writes; checked %0d dial results.",
                 pixels_taken, cfg_writes, results_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end
endmodule
